// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the display rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/adsd_pkg.sv =====
// types, codes and segment table for the decimal display block
package adsd_pkg;

   localparam int SEG_WIDTH   = 8;
   localparam int BCD_WIDTH   = 4;
   localparam int LEVEL_BITS  = 6;

   localparam logic [SEG_WIDTH-1:0]  SEG_BLANK   = 8'hFF;
   localparam logic [SEG_WIDTH-1:0]  SELECT_BASE = 8'h10;
   localparam logic [LEVEL_BITS-1:0] LEVEL_OFF   = 6'h3F;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_SCAN   = 2'd1,
      OP_SWITCH = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CONV = 2'b10
   } state_type;

   // status from the serial converter to the top level
   typedef struct packed {
      logic busy;
      logic done;
      logic overflow;
   } conv_status_type;

   // active-low seven-segment pattern of one decimal digit
   function automatic logic [SEG_WIDTH-1:0] seg_encode(input logic [BCD_WIDTH-1:0] digit);
      logic [SEG_WIDTH-1:0] pattern;
      case (digit)
         4'd0:    pattern = 8'h03;
         4'd1:    pattern = 8'h9F;
         4'd2:    pattern = 8'h25;
         4'd3:    pattern = 8'h0D;
         4'd4:    pattern = 8'h99;
         4'd5:    pattern = 8'h49;
         4'd6:    pattern = 8'h41;
         4'd7:    pattern = 8'h1F;
         4'd8:    pattern = 8'h01;
         4'd9:    pattern = 8'h09;
         default: pattern = SEG_BLANK;
      endcase
      return pattern;
   endfunction

endpackage

// ===== rtl/core/adsd_bcd_conv.sv =====
// bit-serial binary to bcd converter (shift and add-3)
module adsd_bcd_conv
   import adsd_pkg::*;
#(
   parameter int DIGIT_COUNT = 4,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [SAMPLE_BITS-1:0]                value,
   output conv_status_type                       status,
   output logic [DIGIT_COUNT-1:0][BCD_WIDTH-1:0] digits
);

   localparam int CW = $clog2(SAMPLE_BITS + 1);

   logic [SAMPLE_BITS-1:0]                shift_ff, shift_in;
   logic [DIGIT_COUNT-1:0][BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [DIGIT_COUNT-1:0][BCD_WIDTH-1:0] adj;
   logic [CW-1:0]                         count_ff, count_in;
   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic                                  ovf_ff, ovf_in;

   // add 3 to every digit of five or more, then shift one bit in
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      ovf_in   = ovf_ff;
      if (start) begin
         shift_in = value;
         bcd_in   = '0;
         count_in = CW'(SAMPLE_BITS);
         busy_in  = 1'b1;
         ovf_in   = 1'b0;
      end else if (busy_ff) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (i == 0) begin
               bcd_in[i] = {adj[i][BCD_WIDTH-2:0], shift_ff[SAMPLE_BITS-1]};
            end else begin
               bcd_in[i] = {adj[i][BCD_WIDTH-2:0], adj[i-1][BCD_WIDTH-1]};
            end
         end
         // carry out of the top digit means the value has more digits
         ovf_in   = ovf_ff | adj[DIGIT_COUNT-1][BCD_WIDTH-1];
         shift_in = shift_ff << 1;
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      ovf_ff   <= ovf_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;
   assign digits          = bcd_ff;

endmodule

// ===== rtl/core/adc_decimal_seven_segment_display.sv =====
// panel-meter display: level bar plus multiplexed decimal seven-segment readout
// scan ticks, switch samples, frozen samples and unused codes: one word per cycle unless stalled,
// result next cycle; a converter sample holds requests until conversion end, paced by the
// bit-serial shift-and-add-3 converter that moves one sample bit per cycle
// synchronous active-high reset: all digits blank, bar dark, scan index 0, not frozen,
// nothing pending; no clearing pass
module adc_decimal_seven_segment_display
   import adsd_pkg::*;
#(
   parameter int DIGIT_COUNT = 4,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_switch_level,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SEG_WIDTH-1:0]   rsp_segments,
   output logic [SEG_WIDTH-1:0]   rsp_digit_select,
   output logic [LEVEL_BITS-1:0]  rsp_level_leds,
   output logic                   rsp_frozen
);

   `include "assert_macros.svh"

   localparam int IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   // control
   state_type       state_ff, state_in;
   logic            req_accept;
   logic            conv_start;
   logic            conv_done;
   logic            fire;
   opcode_type      op;
   conv_status_type conv_status;

   logic [DIGIT_COUNT-1:0][BCD_WIDTH-1:0] conv_digits;
   logic [DIGIT_COUNT-1:0][SEG_WIDTH-1:0] enc_pattern;
   logic [LEVEL_BITS-1:0]                 level_top;

   // display state
   logic [DIGIT_COUNT-1:0][SEG_WIDTH-1:0] pending_ff, pending_in;
   logic [DIGIT_COUNT-1:0][SEG_WIDTH-1:0] shown_ff, shown_in;
   logic                                  pvalid_ff, pvalid_in;
   logic [IW-1:0]                         scan_ff, scan_in;
   logic [LEVEL_BITS-1:0]                 level_ff, level_in;
   logic                                  switch_prev_ff, switch_prev_in;
   logic                                  frozen_ff, frozen_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SEG_WIDTH-1:0]  rsp_seg_ff, rsp_sel_ff;
   logic [LEVEL_BITS-1:0] rsp_level_ff;
   logic                  rsp_frozen_ff;

   // hold requests while converting or while an old word is still stuck at the output
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign op         = opcode_type'(req_opcode);
   assign conv_start = req_accept && (op == OP_SAMPLE) && !frozen_ff;
   assign conv_done  = (state_ff == ST_CONV) && conv_status.done;
   // a word is produced on every accept except a live sample, which answers at conversion end
   assign fire       = (req_accept && !conv_start) || conv_done;

   adsd_bcd_conv #(
      .DIGIT_COUNT(DIGIT_COUNT),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (req_sample),
      .status (conv_status),
      .digits (conv_digits)
   );

   // top six sample bits drive the bar; narrow samples are padded on the right
   generate
      if (SAMPLE_BITS >= LEVEL_BITS) begin : g_level_wide
         assign level_top = req_sample[SAMPLE_BITS-1 -: LEVEL_BITS];
      end else begin : g_level_narrow
         assign level_top = {req_sample, {(LEVEL_BITS - SAMPLE_BITS){1'b0}}};
      end
   endgenerate

   // segment encode with leading-zero blanking; units digit always lit,
   // and nothing blanks when the value overflows the digit count
   always_comb begin
      logic keep;
      keep = conv_status.overflow;
      for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
         keep = keep | (conv_digits[i] != '0);
         enc_pattern[i] = (keep || i == 0) ? seg_encode(conv_digits[i]) : SEG_BLANK;
      end
   end

   // state update per word
   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      shown_in       = shown_ff;
      pvalid_in      = pvalid_ff;
      scan_in        = scan_ff;
      level_in       = level_ff;
      switch_prev_in = switch_prev_ff;
      frozen_in      = frozen_ff;
      if (conv_done) begin
         pending_in = enc_pattern;
         pvalid_in  = 1'b1;
         state_in   = ST_IDLE;
      end else if (req_accept) begin
         case (op)
            OP_SAMPLE: begin
               if (!frozen_ff) begin
                  level_in = ~level_top;
                  state_in = ST_CONV;
               end
            end
            OP_SCAN: begin
               // wrap of the multiplex index swaps in a pending set
               if (scan_ff == IW'(DIGIT_COUNT - 1)) begin
                  scan_in = '0;
                  if (pvalid_ff) begin
                     shown_in  = pending_ff;
                     pvalid_in = 1'b0;
                  end
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            OP_SWITCH: begin
               // press is released-to-pressed
               switch_prev_in = req_switch_level;
               if (switch_prev_ff && !req_switch_level) begin
                  frozen_in = !frozen_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pending_ff     <= {DIGIT_COUNT{SEG_BLANK}};
         shown_ff       <= {DIGIT_COUNT{SEG_BLANK}};
         pvalid_ff      <= 1'b0;
         scan_ff        <= '0;
         level_ff       <= LEVEL_OFF;
         switch_prev_ff <= 1'b0;
         frozen_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pending_ff     <= pending_in;
         shown_ff       <= shown_in;
         pvalid_ff      <= pvalid_in;
         scan_ff        <= scan_in;
         level_ff       <= level_in;
         switch_prev_ff <= switch_prev_in;
         frozen_ff      <= frozen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // output word reflects the state after the item
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_seg_ff    <= shown_in[scan_in];
         rsp_sel_ff    <= SELECT_BASE << scan_in;
         rsp_level_ff  <= level_in;
         rsp_frozen_ff <= frozen_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segments     = rsp_seg_ff;
   assign rsp_digit_select = rsp_sel_ff;
   assign rsp_level_leds   = rsp_level_ff;
   assign rsp_frozen       = rsp_frozen_ff;

   `ASSERT_IMPLIES(a_done_in_conv, clock, reset, conv_status.done, state_ff == ST_CONV, "converter done outside conversion")
   `ASSERT_IMPLIES(a_stall_in_conv, clock, reset, state_ff == ST_CONV, req_stall, "request taken during conversion")
   `ASSERT_IMPLIES(a_freeze_cause, clock, reset, !$past(reset) && (frozen_ff != $past(frozen_ff)), $past(req_accept) && ($past(req_opcode) == OP_SWITCH), "freeze changed without a switch word")
   `ASSERT_NEXT(a_sample_answers, clock, reset, conv_done, rsp_valid_ff, "conversion end gave no response")

endmodule
